>>> design/grd_pkg.sv
package grd_pkg;

  localparam int unsigned BlockBytes = 36;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [1:0] {
    FMT_FP32  = 2'd0,
    FMT_F16   = 2'd1,
    FMT_BF16  = 2'd2,
    FMT_NVFP4 = 2'd3
  } fmt_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_SCALE = 2'd1,
    ERR_ROW   = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    OP_WORD  = 2'd0,
    OP_SCALE = 2'd1,
    OP_PAIR  = 2'd2,
    OP_ERROR = 2'd3
  } op_e;

  localparam logic [0:0] RegFormat = 1'b0;
  localparam logic [0:0] RegGlobal = 1'b1;

  localparam logic [31:0] OneBits   = 32'h3F80_0000;
  localparam logic [31:0] CanonNan  = 32'h7FC0_0000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       row_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value_bits;
    logic [5:0]  element_index;
    logic        last;
    logic [1:0]  error_code;
  } out_item_t;

  // Classified work for the back end.
  typedef struct packed {
    op_e         op;
    logic [31:0] word;
    logic [7:0]  data_byte;
    logic [1:0]  group;
    logic [2:0]  offset;
    err_e        err;
  } task_t;

  // e2m1 value as fp32 bits, sign from bit 3.
  function automatic logic [31:0] e2m1_bits(input logic [3:0] nib);
    logic [31:0] m;
    case (nib[2:0])
      3'd0: m = 32'h0000_0000;
      3'd1: m = 32'h3F00_0000;
      3'd2: m = 32'h3F80_0000;
      3'd3: m = 32'h3FC0_0000;
      3'd4: m = 32'h4000_0000;
      3'd5: m = 32'h4040_0000;
      3'd6: m = 32'h4080_0000;
      default: m = 32'h40C0_0000;
    endcase
    return {nib[3], m[30:0]};
  endfunction

  // e4m3fn to fp32 bits, exact.
  function automatic logic [31:0] e4m3_bits(input logic [7:0] b);
    logic [3:0] e;
    logic [2:0] m;
    logic [7:0] ex;
    logic [22:0] fr;
    e = b[6:3];
    m = b[2:0];
    ex = 8'd0;
    fr = 23'd0;
    if (e == 4'd15 && m == 3'd7) begin
      return CanonNan;
    end
    if (e != 4'd0) begin
      ex = 8'(e) + 8'd120;
      fr = {m, 20'd0};
    end else if (m[2]) begin
      ex = 8'd120;
      fr = {m[1:0], 21'd0};
    end else if (m[1]) begin
      ex = 8'd119;
      fr = {m[0], 22'd0};
    end else if (m[0]) begin
      ex = 8'd118;
    end
    return {b[7], ex, fr};
  endfunction

  function automatic logic [31:0] f16_bits(input logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [7:0]  ex;
    logic [9:0]  mn;
    int unsigned k;
    e = h[14:10];
    m = h[9:0];
    ex = 8'd0;
    mn = 10'd0;
    if (e == 5'd31) begin
      return {h[15], 8'hFF, m, 13'd0};
    end
    if (e != 5'd0) begin
      return {h[15], 8'(e) + 8'd112, m, 13'd0};
    end
    if (m == 10'd0) begin
      return {h[15], 31'd0};
    end
    k = 0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) k = i;
    end
    ex = 8'd103 + 8'(k);
    mn = 10'(m << (10 - k));
    return {h[15], ex, mn, 13'd0};
  endfunction

endpackage

>>> design/grd_fmul.sv
// Two-stage fp32 multiplier, round to nearest even, subnormals honoured,
// NaN results canonical.
module grd_fmul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o
);

  localparam logic [31:0] CANON = grd_pkg::CanonNan;

  logic        s_q, nan_q, inf_q, zero_q;
  logic [47:0] prod_q;
  logic signed [10:0] exp_q;

  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

  always_comb begin
    ea = a_i[30:23];
    eb = b_i[30:23];
    ma = {ea != 8'd0, a_i[22:0]};
    mb = {eb != 8'd0, b_i[22:0]};
    a_nan = (ea == 8'hFF) && (a_i[22:0] != 23'd0);
    b_nan = (eb == 8'hFF) && (b_i[22:0] != 23'd0);
    a_inf = (ea == 8'hFF) && (a_i[22:0] == 23'd0);
    b_inf = (eb == 8'hFF) && (b_i[22:0] == 23'd0);
    a_zero = a_i[30:0] == 31'd0;
    b_zero = b_i[30:0] == 31'd0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q    <= a_i[31] ^ b_i[31];
      nan_q  <= a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
      inf_q  <= a_inf || b_inf;
      zero_q <= a_zero || b_zero;
      prod_q <= ma * mb;
      exp_q  <= 11'(ea == 8'd0 ? 10'sd1 : $signed({2'b00, ea}))
              + 11'(eb == 8'd0 ? 10'sd1 : $signed({2'b00, eb})) - 11'sd127;
    end
  end

  logic [5:0]  lz;
  logic [47:0] nrm;
  logic signed [11:0] e1;
  logic [49:0] sh;
  logic [23:0] mant;
  logic        g, st, rup;
  logic [24:0] mr;
  logic signed [11:0] ef;
  logic [11:0] rs;

  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (prod_q[i]) lz = 6'(47 - i);
    end
    nrm = prod_q << lz;
    // nrm[47] is the leading one, value = nrm * 2^(e1-127-47) with e1 biased
    e1 = 12'(exp_q) + 12'sd1 - 12'(lz);
    sh = {nrm, 2'b00};
    if (e1 < 12'sd1) begin
      rs = 12'(12'sd1 - e1);
      if (rs > 12'd49) begin
        sh = {49'd0, nrm != 48'd0};
      end else begin
        sh = ({nrm, 2'b00} >> rs) | {49'd0, |({nrm, 2'b00} & ~({50{1'b1}} << rs))};
      end
      ef = 12'sd0;
    end else begin
      rs = 12'd0;
      ef = e1;
    end
    mant = sh[49:26];
    g    = sh[25];
    st   = |sh[24:0];
    rup  = g && (st || mant[0]);
    mr   = {1'b0, mant} + 25'(rup);
    if (mr[24]) begin
      mr = mr >> 1;
      ef = ef + 12'sd1;
    end else if (ef == 12'sd0 && mr[23]) begin
      ef = 12'sd1;
    end
    if (nan_q) begin
      p_o = CANON;
    end else if (inf_q) begin
      p_o = {s_q, 8'hFF, 23'd0};
    end else if (zero_q) begin
      p_o = {s_q, 31'd0};
    end else if (ef >= 12'sd255) begin
      p_o = {s_q, 8'hFF, 23'd0};
    end else begin
      p_o = {s_q, ef[7:0], mr[22:0]};
    end
  end

endmodule

>>> design/grd_front.sv
// Front end: tracks the position in the word or block and classifies each item.
module grd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_wr_i,
  input  grd_pkg::fmt_e     fmt_i,
  input  logic              scale_ok_i,
  input  logic              push_i,
  input  grd_pkg::in_item_t item_i,
  output grd_pkg::task_t    task_o
);

  logic [5:0]  pos_q, pos_d;
  logic [23:0] pend_q, pend_d;
  logic [5:0]  unit, pos, nxt, q;

  always_comb begin
    unit = fmt_i == grd_pkg::FMT_NVFP4 ? 6'd36 : (fmt_i == grd_pkg::FMT_FP32 ? 6'd4 : 6'd2);
    pos  = pos_q >= unit ? 6'd0 : pos_q;
    nxt  = pos + 6'd1 == unit ? 6'd0 : pos + 6'd1;
    q    = pos - 6'd4;
    pos_d  = pos_q;
    pend_d = pend_q;
    task_o = '0;
    task_o.data_byte = item_i.data_byte;
    task_o.group  = q[4:3];
    task_o.offset = q[2:0];
    task_o.err    = grd_pkg::ERR_NONE;
    task_o.word = {item_i.data_byte, 24'd0} >> (6'd8 * (6'd3 - {4'd0, pos[1:0]}))
                  | {8'd0, pend_q};
    if (!scale_ok_i) begin
      task_o.op = grd_pkg::OP_ERROR;
      task_o.err = grd_pkg::ERR_SCALE;
      pos_d = 6'd0;
      pend_d = 24'd0;
    end else if (item_i.row_last && nxt != 6'd0) begin
      task_o.op = grd_pkg::OP_ERROR;
      task_o.err = grd_pkg::ERR_ROW;
      pos_d = 6'd0;
      pend_d = 24'd0;
    end else begin
      pos_d = nxt;
      if (fmt_i == grd_pkg::FMT_NVFP4) begin
        task_o.op = pos < 6'd4 ? grd_pkg::OP_SCALE : grd_pkg::OP_PAIR;
        task_o.group = pos < 6'd4 ? pos[1:0] : q[4:3];
      end else begin
        task_o.op = grd_pkg::OP_WORD;
        if (nxt != 6'd0) begin
          pend_d = task_o.word[23:0];
        end else begin
          pend_d = 24'd0;
        end
      end
    end
    if (!push_i) begin
      pos_d = pos_q;
      pend_d = pend_q;
    end
    if (cfg_wr_i) begin
      pos_d = 6'd0;
      pend_d = 24'd0;
    end
  end

  // A word op is only forwarded when the word completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 6'd0;
      pend_q <= 24'd0;
    end else begin
      pos_q  <= pos_d;
      pend_q <= pend_d;
    end
  end

endmodule

>>> design/grd_back.sv
// Back end: decodes word formats, passes error items on, forms group scales,
// emits two results per nvfp4 payload byte through a shared multiplier.
module grd_back #(
  parameter int unsigned OutDepth = grd_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  grd_pkg::fmt_e      fmt_i,
  input  logic [31:0]        gscale_i,
  input  logic               t_valid_i,
  output logic               t_ready_o,
  input  grd_pkg::task_t     task_i,
  input  logic               pop_i,
  output logic               empty_o,
  output grd_pkg::out_item_t item_o
);

  localparam int unsigned AW = $clog2(OutDepth);

  // Sequencer: phase 0 handles first half, phase 1 the high nibble.
  logic        ph_q, ph_d;
  logic [31:0] gs_q [4];
  logic        issue, second;
  logic [31:0] ma, mb;

  // Pipeline tracking of the multiplier's registered stage.
  typedef struct packed {
    logic        v;
    logic        is_scale;
    logic        direct;
    logic [31:0] dval;
    logic [1:0]  group;
    logic [5:0]  idx;
    logic        last;
    logic [1:0]  err;
  } trk_t;
  trk_t s1_q, s1_d;

  logic [31:0] prod;

  // Output queue.
  grd_pkg::out_item_t mem_q [OutDepth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          wr, rd;
  grd_pkg::out_item_t wdata;

  // Reserve room: at most one result in the multiplier stage.
  logic room;
  assign room = cnt_q + {{AW{1'b0}}, s1_q.v} < (AW+1)'(OutDepth - 1);

  logic [5:0] base;
  always_comb begin
    base = {task_i.group, 1'b0, task_i.offset};
    second = task_i.op == grd_pkg::OP_PAIR && ph_q;
    issue = t_valid_i && room;
    t_ready_o = 1'b0;
    ph_d = ph_q;
    s1_d = '0;
    ma = 32'd0;
    mb = 32'd0;
    if (issue) begin
      s1_d.v = 1'b1;
      s1_d.group = task_i.group;
      s1_d.err = task_i.err;
      case (task_i.op)
        grd_pkg::OP_ERROR: begin
          s1_d.direct = 1'b1;
          s1_d.last = 1'b1;
          t_ready_o = 1'b1;
        end
        grd_pkg::OP_WORD: begin
          s1_d.direct = 1'b1;
          s1_d.last = 1'b1;
          case (fmt_i)
            grd_pkg::FMT_FP32: s1_d.dval = task_i.word;
            grd_pkg::FMT_F16:  s1_d.dval = grd_pkg::f16_bits(task_i.word[15:0]);
            default:           s1_d.dval = {task_i.word[15:0], 16'd0};
          endcase
          t_ready_o = 1'b1;
        end
        grd_pkg::OP_SCALE: begin
          s1_d.is_scale = 1'b1;
          ma = grd_pkg::e4m3_bits(task_i.data_byte);
          mb = gscale_i;
          t_ready_o = 1'b1;
        end
        default: begin
          ma = grd_pkg::e2m1_bits(second ? task_i.data_byte[7:4] : task_i.data_byte[3:0]);
          mb = gs_q[task_i.group];
          s1_d.idx = second ? base + 6'd8 : base;
          s1_d.last = second;
          ph_d = ~ph_q;
          t_ready_o = second;
        end
      endcase
    end
  end

  grd_fmul u_mul (
    .clk_i (clk_i),
    .en_i  (issue),
    .a_i   (ma),
    .b_i   (mb),
    .p_o   (prod)
  );

  always_comb begin
    wr = s1_q.v && !s1_q.is_scale;
    wdata.value_bits = s1_q.direct ? s1_q.dval : prod;
    wdata.element_index = s1_q.idx;
    wdata.last = s1_q.last;
    wdata.error_code = s1_q.err;
    rd = pop_i && cnt_q != '0;
  end

  always_ff @(posedge clk_i) begin
    if (s1_q.v && s1_q.is_scale) begin
      gs_q[s1_q.group] <= prod;
    end
    if (wr) begin
      mem_q[wp_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= 1'b0;
      s1_q  <= '0;
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      ph_q <= ph_d;
      s1_q <= s1_d;
      if (wr) wp_q <= (wp_q == AW'(OutDepth - 1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == AW'(OutDepth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  assign empty_o = cnt_q == '0;
  assign item_o  = mem_q[rp_q];

endmodule

>>> design/gguf_row_dequantizer_top.sv
// Row dequantizer: bytes of a weight row go in one item at a time and come out
// as fp32 items (pass-through, f16, bf16 or NVFP4). A front end classifies bytes,
// a two-entry task queue decouples it from the back end, and the back end runs
// one shared two-stage fp32 multiplier. An nvfp4 payload byte issues its two
// results one after the other, low nibble first, through the single multiplier
// issue slot. A result passes through the task queue, the multiplier stage
// register and the output queue before it reaches the output ports.
module gguf_row_dequantizer_top #(
  parameter int unsigned OutDepth = grd_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  grd_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output grd_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  grd_pkg::fmt_e fmt_q;
  logic [31:0]   gscale_q;
  logic          scale_ok, cfg_wr, acc;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= grd_pkg::FMT_FP32;
      gscale_q <= grd_pkg::OneBits;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        grd_pkg::RegFormat: fmt_q <= grd_pkg::fmt_e'(cfg_data_i[1:0]);
        grd_pkg::RegGlobal: gscale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign scale_ok = fmt_q == grd_pkg::FMT_NVFP4
                  ? (gscale_q >= 32'd1 && gscale_q <= 32'h7F7F_FFFF)
                  : gscale_q == grd_pkg::OneBits;

  grd_pkg::task_t tk, tq_mem [2], tq_out;
  logic [1:0] tq_cnt_q;
  logic       tq_wp_q, tq_rp_q, tq_rd, fwd;
  logic       word_done;

  assign acc = push && !full;
  assign full = tq_cnt_q == 2'd2;

  grd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_wr_i   (cfg_wr),
    .fmt_i      (fmt_q),
    .scale_ok_i (scale_ok),
    .push_i     (acc),
    .item_i     (in_item_i),
    .task_o     (tk)
  );

  // Non-final bytes of a word only update the front end.
  assign fwd = acc && !(tk.op == grd_pkg::OP_WORD && !word_done);

  logic [5:0] front_unit;
  assign front_unit = fmt_q == grd_pkg::FMT_FP32 ? 6'd4 : 6'd2;
  logic [5:0] fpos_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fpos_q <= 6'd0;
    else if (cfg_wr) fpos_q <= 6'd0;
    else if (acc) fpos_q <= (fpos_q + 6'd1 >= front_unit || tk.op != grd_pkg::OP_WORD)
                            ? 6'd0 : fpos_q + 6'd1;
  end
  assign word_done = fpos_q + 6'd1 >= front_unit;

  always_ff @(posedge clk_i) begin
    if (fwd) tq_mem[tq_wp_q] <= tk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tq_cnt_q <= 2'd0;
      tq_wp_q <= 1'b0;
      tq_rp_q <= 1'b0;
    end else begin
      if (fwd) tq_wp_q <= ~tq_wp_q;
      if (tq_rd) tq_rp_q <= ~tq_rp_q;
      tq_cnt_q <= tq_cnt_q + 2'(fwd) - 2'(tq_rd);
    end
  end

  logic t_ready;
  assign tq_out = tq_mem[tq_rp_q];
  assign tq_rd = t_ready && tq_cnt_q != 2'd0;

  grd_back #(.OutDepth(OutDepth)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fmt_i     (fmt_q),
    .gscale_i  (gscale_q),
    .t_valid_i (tq_cnt_q != 2'd0),
    .t_ready_o (t_ready),
    .task_i    (tq_out),
    .pop_i     (pop),
    .empty_o   (empty),
    .item_o    (out_item_o)
  );

endmodule
